// ----- rtl/dpe_pkg.sv -----
package dpe_pkg;

    // Field widths fixed by the item format.
    localparam int CODE_W  = 8;
    localparam int ENTRY_W = 7;
    localparam int PAIR_W  = 2 * CODE_W;
    localparam int CFG_W   = 7;

    // Default depth of the pair table.
    localparam int DEF_PAIR_ENTRIES = 64;

    // Substituted pairs are coded as this base plus the entry index.
    localparam logic [CODE_W-1:0] PAIR_CODE_BASE = 8'd155;

    // Input tdata layout, lowest bit first.
    localparam int S_ENTRY_LSB  = 0;
    localparam int S_FIRST_LSB  = S_ENTRY_LSB + ENTRY_W;
    localparam int S_SECOND_LSB = S_FIRST_LSB + CODE_W;
    localparam int S_BYTE_LSB   = S_SECOND_LSB + CODE_W;
    localparam int S_USED_W     = S_BYTE_LSB + CODE_W;
    localparam int S_TDATA_W    = ((S_USED_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = CODE_W;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_DATA = 1'b1
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // Outcome of one table search, valid in the cycle that done is high.
    typedef struct packed {
        logic               done;
        logic               hit;
        logic [ENTRY_W-1:0] idx;
    } scan_status_t;

    // One result beat waiting in the output queue.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } out_beat_t;

endpackage

// ----- rtl/dpe_pair_scan.sv -----
module dpe_pair_scan
    import dpe_pkg::*;
#(
    parameter int PAIR_ENTRIES = DEF_PAIR_ENTRIES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [ENTRY_W-1:0] wr_idx,
    input  logic [PAIR_W-1:0]  wr_pair,
    input  logic               start,
    input  logic [PAIR_W-1:0]  want,
    input  logic [CFG_W-1:0]   pairs_in_use,
    output scan_status_t       status
);

    localparam int IDX_W = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
    localparam int CNT_W = $clog2(PAIR_ENTRIES + 1);

    logic [PAIR_W-1:0] mem [PAIR_ENTRIES];

    logic              busy_reg;
    logic [CNT_W-1:0]  issue_cnt_reg;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [PAIR_W-1:0] rd_data_reg;
    logic [PAIR_W-1:0] want_reg;

    logic [CNT_W-1:0]  limit;
    logic              hit_now;
    logic              issue;
    logic              finish;

    // Entries beyond the configured count, or beyond the table, are not searched.
    assign limit = (pairs_in_use < CFG_W'(PAIR_ENTRIES)) ? CNT_W'(pairs_in_use)
                                                         : CNT_W'(PAIR_ENTRIES);

    assign hit_now = rd_valid_reg && (rd_data_reg == want_reg);
    assign issue   = busy_reg && (issue_cnt_reg < limit) && !hit_now;
    assign finish  = busy_reg && (hit_now || (issue_cnt_reg >= limit));

    // Table memory: one write port for load items, one registered read port
    // for the search.
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_idx < ENTRY_W'(PAIR_ENTRIES))) begin
            mem[wr_idx[IDX_W-1:0]] <= wr_pair;
        end
        if (issue) begin
            rd_data_reg <= mem[issue_cnt_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            issue_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= issue;
            if (start) begin
                busy_reg      <= 1'b1;
                issue_cnt_reg <= '0;
            end else begin
                if (finish) begin
                    busy_reg <= 1'b0;
                end
                if (issue) begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_idx_reg <= issue_cnt_reg[IDX_W-1:0];
        end
        if (start) begin
            want_reg <= want;
        end
    end

    assign status.done = finish;
    assign status.hit  = hit_now;
    assign status.idx  = ENTRY_W'(rd_idx_reg);

endmodule

// ----- rtl/digram_pair_encoder_core.sv -----
// Greedy digram encoder. Input beats on the s_ channel either load one entry
// of the pair table (s_tuser low) or carry one character of a word (s_tuser
// high, s_tlast on the final character). Result beats on the m_ channel carry
// a plain character or a pair code, with m_tlast on the last beat of a word.
// cfg_wr_en writes cfg_wr_data into the count of table entries searched; the
// user must write it only while the block is idle; the block does not enforce this.
//
// A load beat, and a character that arrives while nothing is held, are taken
// without a search. A character that arrives while another is held starts a
// search of the table memory, one entry read per cycle through its single
// read port, until the first match or until the configured count of entries
// (capped at the table depth) has been read.
// A result is written into a four-beat output queue at the end of its beat.
//
// Reset clears the held character, the configured count and the queue; the
// table contents are undefined until loaded. When the receiver stalls, the
// queue keeps taking results, and s_tready drops only while fewer than two
// queue slots are free, or while a search is running.
module digram_pair_encoder_core
    import dpe_pkg::*;
#(
    parameter int PAIR_ENTRIES = DEF_PAIR_ENTRIES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration: count of table entries searched.
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    // Input channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_index[6:0], pair_first[14:7], pair_second[22:15], data_byte[30:23]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,   // opcode: 0 load, 1 data byte
    input  logic                 s_tlast,   // word_end
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // code_byte[7:0]
    output logic                 m_tlast    // word_done
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    state_t            state_reg;
    state_t            state_next;

    logic [CFG_W-1:0]  pairs_in_use_reg;
    logic [CODE_W-1:0] held_char_reg;
    logic [CODE_W-1:0] held_char_next;
    logic              held_valid_reg;
    logic              held_valid_next;
    logic [CODE_W-1:0] byte_reg;
    logic              end_reg;

    out_beat_t         q_reg [QDEPTH];
    logic [QPTR_W-1:0] head_reg;
    logic [QPTR_W-1:0] tail_reg;
    logic [QCNT_W-1:0] count_reg;

    logic              accept;
    logic              pop;
    op_t               in_op;
    logic [ENTRY_W-1:0] in_entry;
    logic [PAIR_W-1:0] in_pair;
    logic [CODE_W-1:0] in_byte;

    logic              scan_start;
    scan_status_t      scan_status;
    logic              push_a;
    logic              push_b;
    out_beat_t         beat_a;
    out_beat_t         beat_b;

    assign in_op    = op_t'(s_tuser);
    assign in_entry = s_tdata[S_ENTRY_LSB +: ENTRY_W];
    assign in_pair  = {s_tdata[S_FIRST_LSB +: CODE_W], s_tdata[S_SECOND_LSB +: CODE_W]};
    assign in_byte  = s_tdata[S_BYTE_LSB +: CODE_W];

    assign accept = s_tvalid && s_tready;
    assign pop    = m_tvalid && m_tready;

    dpe_pair_scan #(
        .PAIR_ENTRIES (PAIR_ENTRIES)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr_en        (accept && (in_op == OP_LOAD)),
        .wr_idx       (in_entry),
        .wr_pair      (in_pair),
        .start        (scan_start),
        .want         ({held_char_reg, in_byte}),
        .pairs_in_use (pairs_in_use_reg),
        .status       (scan_status)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (in_op == OP_DATA) && held_valid_reg) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_status.done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake, search start, result pushes and held character.
    always_comb begin
        s_tready        = 1'b0;
        scan_start      = 1'b0;
        push_a          = 1'b0;
        push_b          = 1'b0;
        beat_a          = '{code: held_char_reg, last: 1'b0};
        beat_b          = '{code: byte_reg, last: 1'b1};
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                // Room for the two results that one character can cause.
                s_tready = (count_reg <= QCNT_W'(QDEPTH - 2));
                if (accept && (in_op == OP_DATA)) begin
                    if (held_valid_reg) begin
                        scan_start = 1'b1;
                    end else if (s_tlast) begin
                        // A single-character word ends at once.
                        push_a         = 1'b1;
                        beat_a         = '{code: in_byte, last: 1'b1};
                        held_char_next = '0;
                    end else begin
                        held_char_next  = in_byte;
                        held_valid_next = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_status.done) begin
                    push_a = 1'b1;
                    if (scan_status.hit) begin
                        beat_a          = '{code: PAIR_CODE_BASE + CODE_W'(scan_status.idx),
                                            last: end_reg};
                        held_char_next  = '0;
                        held_valid_next = 1'b0;
                    end else if (end_reg) begin
                        push_b          = 1'b1;
                        held_char_next  = '0;
                        held_valid_next = 1'b0;
                    end else begin
                        held_char_next = byte_reg;
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            pairs_in_use_reg <= '0;
            held_char_reg    <= '0;
            held_valid_reg   <= 1'b0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            if (cfg_wr_en) begin
                pairs_in_use_reg <= cfg_wr_data;
            end
            if (pop) begin
                head_reg <= head_reg + 1'b1;
            end
            tail_reg  <= tail_reg + QPTR_W'(push_a) + QPTR_W'(push_b);
            count_reg <= count_reg + QCNT_W'(push_a) + QCNT_W'(push_b) - QCNT_W'(pop);
        end
    end

    // Character and word end of the beat under search, and the queue writes.
    always_ff @(posedge aclk) begin
        if (scan_start) begin
            byte_reg <= in_byte;
            end_reg  <= s_tlast;
        end
        if (push_a) begin
            q_reg[tail_reg] <= beat_a;
        end
        if (push_b) begin
            q_reg[tail_reg + 1'b1] <= beat_b;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = q_reg[head_reg].code;
    assign m_tlast  = q_reg[head_reg].last;

    // A search result only shows up while a search is pending.
    a_done_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_status.done |-> (state_reg == ST_SCAN))
        else $error("search finished outside of a search");

    // The queue never overflows.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("output queue overflow");

    // A character that meets a held one always starts a search.
    a_scan_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_op == OP_DATA) && held_valid_reg) |=> (state_reg == ST_SCAN))
        else $error("held pair did not start a search");

    // Nothing stays held once the last beat of a word is queued.
    a_word_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ((push_a && beat_a.last) || push_b) |=> !held_valid_reg)
        else $error("character held across a word end");

    // No input is taken while a search is in progress.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !s_tready)
        else $error("input accepted during a search");

endmodule

// ----- test/digram_pair_encoder_core_test.sv -----
module digram_pair_encoder_core_test;
    import dpe_pkg::*;

    localparam int TABLE_DEPTH = DEF_PAIR_ENTRIES;
    localparam int HALF_PERIOD = 6;
    // Long enough for a load or a search that is still running when the last
    // expected beat has arrived.
    localparam int DRAIN_CYCLES = 100;
    // Time limit, many times the slowest legal run of this stimulus.
    localparam int RUN_LIMIT = 12 * 600_000;
    localparam int PHASES = 6;

    // One input beat, with every field of the item, used or ignored.
    typedef struct {
        op_t                op;
        logic [ENTRY_W-1:0] entry;
        logic [CODE_W-1:0]  first;
        logic [CODE_W-1:0]  second;
        logic [CODE_W-1:0]  chr;
        logic               word_end;
    } enc_item_t;

    // One result beat as it should appear on the m_ channel.
    typedef struct {
        logic [CODE_W-1:0] code;
        logic              done;
    } code_beat_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    wire                  s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 s_tlast     = 1'b0;
    wire                  m_tvalid;
    logic                 m_tready    = 1'b0;
    wire  [M_TDATA_W-1:0] m_tdata;
    wire                  m_tlast;

    // Our own copy of the encoder state: the pair table, the held character
    // and the configured count of entries searched.
    logic [PAIR_W-1:0] pair_tbl [TABLE_DEPTH];
    logic [CODE_W-1:0] held_char_q  = '0;
    logic              holding      = 1'b0;
    logic [CFG_W-1:0]  scan_count   = '0;

    enc_item_t  pending_items [$];
    code_beat_t expected_codes [$];
    enc_item_t  cur_item;
    int         error_count    = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;

    // Letters that most words and most table pairs are built from, so that
    // the table searches hit often and the first-match order matters.
    string      letters = "etaonshr";

    digram_pair_encoder_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Works out the result beats that one accepted input beat causes and
    // appends them to expected_codes. Load beats only touch the table.
    task automatic encode_beat(input enc_item_t it);
        int                hit;
        int                n;
        logic              have;
        logic [CODE_W-1:0] first_code;
        hit        = -1;
        have       = 1'b0;
        first_code = '0;
        if (it.op == OP_LOAD) begin
            // Indexes past the end of the table are dropped.
            if (it.entry < TABLE_DEPTH) begin
                pair_tbl[it.entry] = {it.first, it.second};
            end
            return;
        end
        // A count above the table depth searches the whole table only.
        n = (scan_count > TABLE_DEPTH) ? TABLE_DEPTH : scan_count;
        if (holding) begin
            for (int i = 0; i < n; i++) begin
                if (hit < 0 && pair_tbl[i] == {held_char_q, it.chr}) begin
                    hit = i;
                end
            end
            have = 1'b1;
            if (hit >= 0) begin
                first_code  = PAIR_CODE_BASE + CODE_W'(hit);
                holding     = 1'b0;
                held_char_q = '0;
            end else begin
                first_code  = held_char_q;
                held_char_q = it.chr;
            end
        end else begin
            held_char_q = it.chr;
            holding     = 1'b1;
        end
        // At the end of a word a held character is flushed and carries the
        // word mark; otherwise the pair code itself is the last beat.
        if (it.word_end && holding) begin
            if (have) begin
                expected_codes.push_back('{first_code, 1'b0});
            end
            expected_codes.push_back('{held_char_q, 1'b1});
            holding     = 1'b0;
            held_char_q = '0;
        end else if (have) begin
            expected_codes.push_back('{first_code, it.word_end});
        end
    endtask

    task automatic note_error(input string what);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", what);
        end
    endtask

    function automatic logic [CODE_W-1:0] pick_char();
        if ($urandom_range(99) < 85) begin
            return letters[$urandom_range(letters.len() - 1)];
        end
        return CODE_W'($urandom_range(255, 1));
    endfunction

    // The ignored fields of each beat get random values so that the block
    // is seen to ignore them.
    function automatic enc_item_t load_item(input int idx, input logic [CODE_W-1:0] a,
                                            input logic [CODE_W-1:0] b);
        enc_item_t it;
        it.op       = OP_LOAD;
        it.entry    = ENTRY_W'(idx);
        it.first    = a;
        it.second   = b;
        it.chr      = CODE_W'($urandom);
        it.word_end = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic enc_item_t char_item(input logic [CODE_W-1:0] c, input logic last);
        enc_item_t it;
        it.op       = OP_DATA;
        it.entry    = ENTRY_W'($urandom);
        it.first    = CODE_W'($urandom);
        it.second   = CODE_W'($urandom);
        it.chr      = c;
        it.word_end = last;
        return it;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            pending_items.push_back(char_item(s[i], i == s.len() - 1));
        end
    endtask

    // A word of random letters, now and then with a table load slipped in
    // between two of its characters.
    task automatic queue_word(input int len);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < 5) begin
                pending_items.push_back(load_item($urandom_range(127), pick_char(),
                                                  pick_char()));
            end
            pending_items.push_back(char_item(pick_char(), k == len - 1));
        end
    endtask

    task automatic queue_random(input int count);
        int n;
        int len;
        n = 0;
        while (n < count) begin
            if ($urandom_range(99) < 8) begin
                pending_items.push_back(load_item($urandom_range(127), pick_char(),
                                                  pick_char()));
                n++;
            end else begin
                len = $urandom_range(8, 1);
                queue_word(len);
                n += len;
            end
        end
    endtask

    // Returns once every queued beat has been taken and every expected
    // result beat has come back.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_codes.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // The count register is written only with the block idle, after any
    // search or load still in progress has had time to finish.
    task automatic set_scan_count(input int value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(value);
        scan_count   = CFG_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Driver: presents the next pending beat whenever the channel is free,
    // idling at random with the current percentage. A beat is handed to the
    // predictor at the edge where it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                encode_beat(cur_item);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({cur_item.chr, cur_item.second, cur_item.first,
                                            cur_item.entry});
                    s_tuser  <= cur_item.op;
                    s_tlast  <= cur_item.word_end;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every accepted result beat is checked against the oldest
    // expectation. The receiver stalls at random with the current percentage.
    always @(posedge aclk) begin : result_check
        code_beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_codes.size() == 0) begin
                    note_error($sformatf("unexpected result beat: code %0d done %0b",
                                         m_tdata, m_tlast));
                end else begin
                    want = expected_codes.pop_front();
                    if (m_tdata !== want.code || m_tlast !== want.done) begin
                        note_error($sformatf({"result beat mismatch: expected code %0d ",
                                              "done %0b, got code %0d done %0b"},
                                             want.code, want.done, m_tdata, m_tlast));
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #RUN_LIMIT;
        $display("digram_pair_encoder_core_test: errors");
        $finish;
    end

    initial begin : stimulus
        int phase_cfg   [PHASES];
        int phase_send  [PHASES];
        int phase_stall [PHASES];
        int phase_items [PHASES];
        phase_cfg   = '{101, 64, 65, 0, 0, 63};
        phase_send  = '{0, 56, 0, 35, 35, 0};
        phase_stall = '{0, 0, 56, 35, 35, 0};
        phase_items = '{85, 75, 70, 55, 75, 60};
        phase_cfg[4] = $urandom_range(101);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Every table entry is written before any search can reach it. The
        // pairs mostly come from the common letters, with a few wide values.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i % 16 == 15) begin
                pending_items.push_back(load_item(i, CODE_W'($urandom_range(255, 1)),
                                                  CODE_W'($urandom_range(255, 1))));
            end else begin
                pending_items.push_back(load_item(i, pick_char(), pick_char()));
            end
        end
        // Entries that the directed words rely on; entry 2 repeats entry 0
        // so that the first match must win.
        pending_items.push_back(load_item(0, "t", "h"));
        pending_items.push_back(load_item(1, "h", "e"));
        pending_items.push_back(load_item(2, "t", "h"));
        pending_items.push_back(load_item(TABLE_DEPTH - 2, 8'd1, 8'd1));
        pending_items.push_back(load_item(TABLE_DEPTH - 1, 8'd255, 8'd255));
        // With a count of zero nothing is ever substituted.
        push_text("th");

        // Count above the table depth: the whole table is searched.
        set_scan_count(101);
        push_text("th");
        push_text("the");
        push_text("hex");
        pending_items.push_back(char_item(8'd255, 1'b0));
        pending_items.push_back(char_item(8'd255, 1'b1));
        pending_items.push_back(char_item(8'd1, 1'b0));
        pending_items.push_back(char_item(8'd1, 1'b1));
        push_text("q");
        // A load in the middle of a word keeps the held character; here it
        // also removes the first copy of the pair, so the duplicate answers.
        pending_items.push_back(char_item("t", 1'b0));
        pending_items.push_back(load_item(0, "q", "q"));
        pending_items.push_back(char_item("h", 1'b1));
        // Loads past the end of the table are dropped.
        pending_items.push_back(load_item(TABLE_DEPTH, "s", "s"));
        pending_items.push_back(load_item(127, "s", "t"));
        // A zero byte is an ordinary character and does not end the word.
        pending_items.push_back(char_item(8'd0, 1'b0));
        pending_items.push_back(char_item("a", 1'b1));
        pending_items.push_back(load_item(0, "t", "h"));

        // Only entry 0 is searched.
        set_scan_count(1);
        push_text("th");
        push_text("he");

        for (int p = 0; p < PHASES; p++) begin
            set_scan_count(phase_cfg[p]);
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_stall[p];
            if (p == 4) begin
                // The sender holds off halfway until the block has drained.
                queue_random(phase_items[p] / 2);
                wait_drained();
                queue_random(phase_items[p] - phase_items[p] / 2);
            end else begin
                queue_random(phase_items[p]);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_codes.size() == 0) begin
            $display("digram_pair_encoder_core_test: clean");
        end else begin
            $display("digram_pair_encoder_core_test: errors");
        end
        $finish;
    end

endmodule
